// ===== hdl/pcd_pkg.sv =====
package pcd_pkg;

  localparam int CHANNELS_DEF = 4;
  localparam int LEVEL_W      = 8;
  localparam int CNT_W        = 14;
  localparam int GATES_W      = 4;
  localparam int CMD_W        = 2;
  localparam int CFG_DATA_W   = 14;
  localparam int CFG_INDEX_W  = 1;

  localparam logic [CMD_W-1:0] CMD_TICK       = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ZERO_CROSS = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RX_BYTE    = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_FULL_ON_LEVEL    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HALF_CYCLE_TICKS = 1'd1;

  localparam logic [LEVEL_W-1:0] FULL_ON_RESET = 8'd248;
  localparam logic [CNT_W-1:0]   HALF_RESET    = 14'd8333;
  localparam logic [CNT_W-1:0]   CNT_MAX       = 14'h3FFF;
  localparam int LEVEL_STEP = 64;
  localparam int DELAY_MUL  = 98;
  localparam int DELAY_DIV  = 3;

  // x / 3 is taken as (x * 21846) >> 16, exact for x below 2^15.
  localparam int DIV3_SHIFT = 16;
  localparam int DIV3_RECIP = ((1 << DIV3_SHIFT) + DELAY_DIV - 1) / DELAY_DIV;
  localparam int CUT_MUL    = DELAY_MUL * DIV3_RECIP;
  localparam int PROD_W     = 30;

  typedef struct packed {
    logic               tick;
    logic               zero_cross;
    logic               rx_en;
    logic [LEVEL_W-1:0] rx_byte;
  } step_t;

  // Phase cut in ticks for an intensity: level * 98 / 3.
  function automatic logic [CNT_W-1:0] cut_of(input logic [LEVEL_W-1:0] lvl);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(lvl) * PROD_W'(CUT_MUL);
    return prod[DIV3_SHIFT +: CNT_W];
  endfunction

  function automatic logic [LEVEL_W-1:0] level_reset(input int c);
    return LEVEL_W'((c * LEVEL_STEP) % 256);
  endfunction

endpackage

// ===== hdl/pcd_evt_if.sv =====
interface pcd_evt_if;
  logic                        valid;
  logic                        ready;
  logic [pcd_pkg::CMD_W-1:0]   cmd;
  logic [pcd_pkg::LEVEL_W-1:0] rx_byte;

  modport source (output valid, cmd, rx_byte, input ready);
  modport sink   (input valid, cmd, rx_byte, output ready);
endinterface

// ===== hdl/pcd_res_if.sv =====
interface pcd_res_if;
  logic                        valid;
  logic                        ready;
  logic [pcd_pkg::GATES_W-1:0] gates;
  logic                        frame_done;

  modport source (output valid, gates, frame_done, input ready);
  modport sink   (input valid, gates, frame_done, output ready);
endinterface

// ===== hdl/phase_cut_dimmer_controller.sv =====
// Channel   Direction  Word
// evt       in         cmd (tick, zero crossing, received byte), rx_byte
// res       out        gates, frame_done; exactly one word per evt word
// cfg_*     in         write enable, register index, data (no read-back)
//
// One event word is taken every cycle while evt.ready is high. The accepting
// edge loads the input register, and the result register is loaded from it
// once it is free or its word is taken, which raises res.valid.
// Both registers advance together, so the block holds one word in each stage
// and keeps accepting while a result waits, as long as the result moves on.
// When res stalls, the input register fills and evt.ready drops.
// Synchronous reset restores levels, phase counter, delays and frame state.
module phase_cut_dimmer_controller #(
  parameter int CHANNELS = pcd_pkg::CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  pcd_evt_if.sink                         evt,
  pcd_res_if.source                       res,
  input  logic                            cfg_we,
  input  logic [pcd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pcd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int OUT_CH = (CHANNELS < pcd_pkg::GATES_W) ? CHANNELS : pcd_pkg::GATES_W;

  logic [pcd_pkg::LEVEL_W-1:0] full_on_level;
  logic [pcd_pkg::CNT_W-1:0]   half_cycle_ticks;

  logic                        s_valid;
  logic [pcd_pkg::CMD_W-1:0]   s_cmd;
  logic [pcd_pkg::LEVEL_W-1:0] s_byte;

  logic                        o_valid;
  logic [pcd_pkg::GATES_W-1:0] o_gates;
  logic                        o_frame_done;

  logic                        out_free;
  logic                        process;
  pcd_pkg::step_t              step;

  logic [pcd_pkg::LEVEL_W-1:0] level [CHANNELS];
  logic [pcd_pkg::CNT_W-1:0]   cut   [CHANNELS];
  logic [CHANNELS-1:0]         gate_next;
  logic                        frame_done;
  logic [pcd_pkg::GATES_W-1:0] gates_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_on_level    <= pcd_pkg::FULL_ON_RESET;
      half_cycle_ticks <= pcd_pkg::HALF_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pcd_pkg::REG_FULL_ON_LEVEL:    full_on_level    <= cfg_data[pcd_pkg::LEVEL_W-1:0];
        pcd_pkg::REG_HALF_CYCLE_TICKS: half_cycle_ticks <= cfg_data[pcd_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free  = !o_valid || res.ready;
  assign process   = s_valid && out_free;
  assign evt.ready = !s_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (evt.ready) begin
      s_valid <= evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      s_cmd  <= evt.cmd;
      s_byte <= evt.rx_byte;
    end
  end

  assign step.tick       = process && (s_cmd == pcd_pkg::CMD_TICK);
  assign step.zero_cross = process && (s_cmd == pcd_pkg::CMD_ZERO_CROSS);
  assign step.rx_en      = process && (s_cmd == pcd_pkg::CMD_RX_BYTE);
  assign step.rx_byte    = s_byte;

  pcd_frame_rx #(.CHANNELS(CHANNELS)) u_frame_rx (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .level      (level),
    .cut        (cut),
    .frame_done (frame_done)
  );

  pcd_phase_core #(.CHANNELS(CHANNELS)) u_phase_core (
    .clk              (clk),
    .rst              (rst),
    .step             (step),
    .full_on_level    (full_on_level),
    .half_cycle_ticks (half_cycle_ticks),
    .level            (level),
    .cut              (cut),
    .gate_next        (gate_next)
  );

  // Only the first four channels reach the gate pins.
  for (genvar i = 0; i < pcd_pkg::GATES_W; i++) begin : g_gates
    if (i < OUT_CH) begin : g_used
      assign gates_word[i] = gate_next[i];
    end else begin : g_unused
      assign gates_word[i] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_free) begin
      o_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      o_gates      <= gates_word;
      o_frame_done <= frame_done;
    end
  end

  assign res.valid      = o_valid;
  assign res.gates      = o_gates;
  assign res.frame_done = o_frame_done;

  a_process_loads_result : assert property (@(posedge clk) disable iff (rst)
    process |=> o_valid)
    else $error("processed word did not reach the result register");

  a_no_drop_on_stall : assert property (@(posedge clk) disable iff (rst)
    (s_valid && o_valid && !res.ready) |-> !evt.ready)
    else $error("input accepted while both stages are full");

  a_frame_done_only_bytes : assert property (@(posedge clk) disable iff (rst)
    (process && s_cmd != pcd_pkg::CMD_RX_BYTE) |=> !o_frame_done)
    else $error("frame_done raised for a non-byte word");

  a_held_result_stable : assert property (@(posedge clk) disable iff (rst)
    (o_valid && !res.ready) |=> ($stable(o_gates) && $stable(o_frame_done)))
    else $error("stalled result changed");

endmodule

// ===== hdl/pcd_frame_rx.sv =====
module pcd_frame_rx #(
  parameter int CHANNELS = pcd_pkg::CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  pcd_pkg::step_t              step,
  output logic [pcd_pkg::LEVEL_W-1:0] level [CHANNELS],
  output logic [pcd_pkg::CNT_W-1:0]   cut   [CHANNELS],
  output logic                        frame_done
);

  localparam int SLOT_W = $clog2(CHANNELS + 1);

  logic [SLOT_W-1:0]        slot;
  logic                     waiting;
  logic [pcd_pkg::CNT_W-1:0] rx_cut;

  assign waiting    = (slot >= SLOT_W'(CHANNELS));
  assign frame_done = step.rx_en && !waiting && (slot == SLOT_W'(CHANNELS - 1));

  // The phase cut is worked out when a level arrives, so the zero crossing
  // only has to subtract it from the half cycle.
  assign rx_cut = pcd_pkg::cut_of(step.rx_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= SLOT_W'(CHANNELS);
      for (int c = 0; c < CHANNELS; c++) begin
        level[c] <= pcd_pkg::level_reset(c);
        cut[c]   <= pcd_pkg::cut_of(pcd_pkg::level_reset(c));
      end
    end else if (step.rx_en) begin
      if (waiting) begin
        if (step.rx_byte == '0) begin
          slot <= '0;
        end
      end else begin
        slot <= slot + SLOT_W'(1);
        for (int c = 0; c < CHANNELS; c++) begin
          if (slot == SLOT_W'(c)) begin
            level[c] <= step.rx_byte;
            cut[c]   <= rx_cut;
          end
        end
      end
    end
  end

endmodule

// ===== hdl/pcd_phase_core.sv =====
module pcd_phase_core #(
  parameter int CHANNELS = pcd_pkg::CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  pcd_pkg::step_t              step,
  input  logic [pcd_pkg::LEVEL_W-1:0] full_on_level,
  input  logic [pcd_pkg::CNT_W-1:0]   half_cycle_ticks,
  input  logic [pcd_pkg::LEVEL_W-1:0] level [CHANNELS],
  input  logic [pcd_pkg::CNT_W-1:0]   cut   [CHANNELS],
  output logic [CHANNELS-1:0]         gate_next
);

  logic [pcd_pkg::CNT_W-1:0] phase_count;
  logic [pcd_pkg::CNT_W-1:0] phase_count_next;
  logic [pcd_pkg::CNT_W-1:0] fire_delay      [CHANNELS];
  logic [pcd_pkg::CNT_W-1:0] fire_delay_next [CHANNELS];
  logic [CHANNELS-1:0]       gate_bits;

  always_comb begin
    phase_count_next = phase_count;
    gate_next        = gate_bits;
    fire_delay_next  = fire_delay;
    if (step.zero_cross) begin
      phase_count_next = '0;
      gate_next        = '0;
      for (int c = 0; c < CHANNELS; c++) begin
        if (level[c] >= full_on_level) begin
          gate_next[c]       = 1'b1;
          fire_delay_next[c] = '0;
        end else if (level[c] == '0) begin
          fire_delay_next[c] = '0;
        end else if (cut[c] >= half_cycle_ticks) begin
          fire_delay_next[c] = pcd_pkg::CNT_W'(1);
        end else begin
          fire_delay_next[c] = half_cycle_ticks - cut[c];
        end
      end
    end else if (step.tick) begin
      if (phase_count != pcd_pkg::CNT_MAX) begin
        phase_count_next = phase_count + pcd_pkg::CNT_W'(1);
      end
      // A zero delay means the channel has nothing pending this half cycle.
      for (int c = 0; c < CHANNELS; c++) begin
        if (fire_delay[c] != '0 && fire_delay[c] == phase_count_next) begin
          gate_next[c] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count <= pcd_pkg::CNT_MAX;
      gate_bits   <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        fire_delay[c] <= '0;
      end
    end else begin
      phase_count <= phase_count_next;
      gate_bits   <= gate_next;
      fire_delay  <= fire_delay_next;
    end
  end

endmodule
